>>> design/lcfr_pkg.sv
`default_nettype none

package lcfr_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
    localparam logic [1:0] KIND_FRAME_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD_LENGTH = 2'd2;
    localparam logic [1:0] KIND_CRC_FAIL   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 8'd1;

    // Register reset values
    localparam logic [7:0] CRC_POLY_RESET    = 8'h07;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;

    // Width of the error totals carried on the output
    localparam int unsigned TOTAL_W = 32;

    // Queue between the parser and the output stage; power of two so the
    // pointers wrap on their own
    localparam int unsigned FIFO_ENTRIES = 2;
    localparam int unsigned QUEUE_PTR_W  = $clog2(FIFO_ENTRIES);
    localparam int unsigned QUEUE_CNT_W  = $clog2(FIFO_ENTRIES + 1);

    // One result record
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         payload_byte;
        logic [7:0]         byte_index;
        logic [7:0]         frame_length;
        logic [7:0]         computed_crc;
        logic [TOTAL_W-1:0] bad_length_total;
        logic [TOTAL_W-1:0] crc_fail_total;
    } t_result;

    // Queue status seen by the output stage
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // MSB-first CRC-8 update over one byte, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/lcfr_front.sv
`default_nettype none

module lcfr_front #(
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [lcfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data,
    input  wire logic                              i_in_valid,
    input  wire logic [7:0]                        i_rx_byte,
    input  wire logic                              i_queue_full,
    output logic                                   o_in_stall,
    output logic                                   o_push,
    output lcfr_pkg::t_result                      o_result
);

    // Parser phases
    localparam logic [1:0] PH_LEN = 2'd0;
    localparam logic [1:0] PH_PAY = 2'd1;
    localparam logic [1:0] PH_CRC = 2'd2;

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};

    logic [7:0]               r_crc_poly;
    logic [7:0]               r_max_payload;
    logic [1:0]               r_phase,      n_phase;
    logic [7:0]               r_exp_len,    n_exp_len;
    logic [7:0]               r_rcv_count,  n_rcv_count;
    logic [7:0]               r_crc,        n_crc;
    logic [COUNTER_WIDTH-1:0] r_len_err,    n_len_err;
    logic [COUNTER_WIDTH-1:0] r_crc_err,    n_crc_err;
    logic [7:0]               crc_next;
    logic [7:0]               count_inc;
    logic                     accept;
    logic [lcfr_pkg::TOTAL_W-1:0] len_err_out;
    logic [lcfr_pkg::TOTAL_W-1:0] crc_err_out;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly    <= lcfr_pkg::CRC_POLY_RESET;
            r_max_payload <= lcfr_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lcfr_pkg::REG_CRC_POLY) begin
                r_crc_poly <= i_cfg_data;
            end
            if (i_cfg_index == lcfr_pkg::REG_MAX_PAYLOAD) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

    // Stall only while the queue has no room
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // CRC seed on a length byte is zero, so one update unit serves both cases
    assign crc_next  = lcfr_pkg::crc8_update((r_phase == PH_PAY) ? r_crc : 8'h00,
                                             i_rx_byte, r_crc_poly);
    assign count_inc = r_rcv_count + 8'd1;

    // Low 32 bits of the totals, zero-extended for narrow counters
    if (COUNTER_WIDTH >= lcfr_pkg::TOTAL_W) begin : g_wide
        assign len_err_out = n_len_err[lcfr_pkg::TOTAL_W-1:0];
        assign crc_err_out = n_crc_err[lcfr_pkg::TOTAL_W-1:0];
    end else begin : g_narrow
        assign len_err_out = {{(lcfr_pkg::TOTAL_W-COUNTER_WIDTH){1'b0}}, n_len_err};
        assign crc_err_out = {{(lcfr_pkg::TOTAL_W-COUNTER_WIDTH){1'b0}}, n_crc_err};
    end

    // Byte classification and next state
    always_comb begin
        n_phase     = r_phase;
        n_exp_len   = r_exp_len;
        n_rcv_count = r_rcv_count;
        n_crc       = r_crc;
        n_len_err   = r_len_err;
        n_crc_err   = r_crc_err;
        o_push      = 1'b0;
        o_result.kind         = lcfr_pkg::KIND_PAYLOAD;
        o_result.payload_byte = i_rx_byte;
        o_result.byte_index   = 8'd0;
        o_result.frame_length = r_exp_len;
        o_result.computed_crc = 8'd0;
        if (accept) begin
            case (r_phase)
                PH_PAY: begin
                    n_crc       = crc_next;
                    n_rcv_count = count_inc;
                    if (count_inc == r_exp_len) begin
                        n_phase = PH_CRC;
                    end
                    o_push              = 1'b1;
                    o_result.byte_index = r_rcv_count;
                end
                PH_CRC: begin
                    if (r_crc == i_rx_byte) begin
                        o_result.kind = lcfr_pkg::KIND_FRAME_GOOD;
                    end else begin
                        o_result.kind = lcfr_pkg::KIND_CRC_FAIL;
                        n_crc_err     = r_crc_err + CNT_ONE;
                    end
                    o_result.computed_crc = r_crc;
                    o_push      = 1'b1;
                    n_phase     = PH_LEN;
                    n_rcv_count = 8'd0;
                    n_crc       = 8'd0;
                end
                default: begin
                    // Length byte; the unused phase code lands here too
                    if (i_rx_byte == 8'd0 || i_rx_byte > r_max_payload) begin
                        n_phase               = PH_LEN;
                        n_len_err             = r_len_err + CNT_ONE;
                        o_push                = 1'b1;
                        o_result.kind         = lcfr_pkg::KIND_BAD_LENGTH;
                        o_result.frame_length = i_rx_byte;
                    end else begin
                        n_exp_len   = i_rx_byte;
                        n_rcv_count = 8'd0;
                        n_crc       = crc_next;
                        n_phase     = PH_PAY;
                    end
                end
            endcase
        end
        o_result.bad_length_total = len_err_out;
        o_result.crc_fail_total   = crc_err_out;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_exp_len   <= 8'd0;
            r_rcv_count <= 8'd0;
            r_crc       <= 8'd0;
            r_len_err   <= '0;
            r_crc_err   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_exp_len   <= n_exp_len;
            r_rcv_count <= n_rcv_count;
            r_crc       <= n_crc;
            r_len_err   <= n_len_err;
            r_crc_err   <= n_crc_err;
        end
    end

endmodule

`default_nettype wire

>>> design/lcfr_queue.sv
`default_nettype none

module lcfr_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire lcfr_pkg::t_result       i_data,
    input  wire logic                    i_pop,
    output lcfr_pkg::t_result            o_data,
    output lcfr_pkg::t_queue_status      o_status
);

    lcfr_pkg::t_result                    r_entry [lcfr_pkg::FIFO_ENTRIES];
    logic [lcfr_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [lcfr_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [lcfr_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic                                 do_push;
    logic                                 do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == lcfr_pkg::QUEUE_CNT_W'(lcfr_pkg::FIFO_ENTRIES));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_entry[r_rd_ptr];

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + lcfr_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + lcfr_pkg::QUEUE_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + lcfr_pkg::QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - lcfr_pkg::QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/lcfr_back.sv
`default_nettype none

module lcfr_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_queue_empty,
    input  wire lcfr_pkg::t_result       i_queue_data,
    input  wire logic                    i_out_stall,
    output logic                         o_pop,
    output logic                         o_out_valid,
    output lcfr_pkg::t_result            o_result
);

    logic              r_valid;
    lcfr_pkg::t_result r_result;

    // Refill the output register when it is empty or being taken
    assign o_pop       = !i_queue_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_queue_data;
        end
    end

endmodule

`default_nettype wire

>>> design/length_crc8_frame_receiver.sv
// Length-prefixed CRC-8 frame receiver.
// Input channel: one received byte per transaction (i_in_valid, o_in_stall,
// i_rx_byte). Output channel: at most one result per byte (o_out_valid,
// i_out_stall, o_out_* fields). A length byte that is accepted gives no result;
// payload bytes, the CRC byte and rejected length bytes give one each.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// index 0 is the CRC polynomial, index 1 the maximum payload length. Write
// only while no byte is in flight. o_cfg_ready is always high.
// Throughput: one byte per cycle while the queue has room. The parser updates
// its state and the CRC (eight unrolled shift-xor steps) in the cycle a byte is
// accepted. A result is registered in a two-entry queue and then in an output
// register before it is presented on the output channel.
// When the receiver stalls, up to three results are held (queue plus output
// register) before o_in_stall rises; stall clears as soon as a result is taken.
// Reset clears the parser to wait for a length byte, zeroes the error counters,
// empties the queue and returns the registers to polynomial 0x07 and
// maximum payload 64.
`default_nettype none

module length_crc8_frame_receiver #(
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lcfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_rx_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_kind,
    output logic [7:0]                             o_payload_byte,
    output logic [7:0]                             o_byte_index,
    output logic [7:0]                             o_frame_length,
    output logic [7:0]                             o_computed_crc,
    output logic [lcfr_pkg::TOTAL_W-1:0]           o_bad_length_total,
    output logic [lcfr_pkg::TOTAL_W-1:0]           o_crc_fail_total
);

    logic                    push;
    logic                    pop;
    lcfr_pkg::t_result       front_result;
    lcfr_pkg::t_result       queue_data;
    lcfr_pkg::t_result       out_result;
    lcfr_pkg::t_queue_status queue_status;

    assign o_cfg_ready = 1'b1;

    // Parser: classifies bytes, keeps CRC and error counters
    lcfr_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_rx_byte      (i_rx_byte),
        .i_queue_full   (queue_status.full),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_result       (front_result)
    );

    // Result queue
    lcfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_result),
        .i_pop    (pop),
        .o_data   (queue_data),
        .o_status (queue_status)
    );

    // Output register stage
    lcfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_empty  (queue_status.empty),
        .i_queue_data   (queue_data),
        .i_out_stall    (i_out_stall),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_result       (out_result)
    );

    assign o_kind             = out_result.kind;
    assign o_payload_byte     = out_result.payload_byte;
    assign o_byte_index       = out_result.byte_index;
    assign o_frame_length     = out_result.frame_length;
    assign o_computed_crc     = out_result.computed_crc;
    assign o_bad_length_total = out_result.bad_length_total;
    assign o_crc_fail_total   = out_result.crc_fail_total;

endmodule

`default_nettype wire

>>> design/lcfr_checker.sv
`default_nettype none

module lcfr_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [1:0]                        o_kind,
    input  wire logic [7:0]                        o_payload_byte,
    input  wire logic [7:0]                        o_byte_index,
    input  wire logic [7:0]                        o_frame_length,
    input  wire logic [7:0]                        o_computed_crc
);

    // A stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output result dropped while stalled");

    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Payload results carry no CRC
    a_payload_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == lcfr_pkg::KIND_PAYLOAD |-> o_computed_crc == 8'd0)
        else $error("payload result with nonzero CRC");

    // Only payload results carry an index
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != lcfr_pkg::KIND_PAYLOAD |-> o_byte_index == 8'd0)
        else $error("nonzero index on a status result");

    // A rejected length reports itself as the frame length
    a_bad_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == lcfr_pkg::KIND_BAD_LENGTH
            |-> o_frame_length == o_payload_byte)
        else $error("bad length result with mismatched frame length");

endmodule

bind length_crc8_frame_receiver lcfr_checker u_lcfr_checker (.*);

`default_nettype wire

>>> tb/length_crc8_frame_receiver_test.sv
`timescale 1ns / 1ps

module length_crc8_frame_receiver_test;

    typedef logic [7:0] t_byte_list [$];

    // Parser phases of the frame tracker
    typedef enum logic [1:0] {
        AWAIT_LENGTH = 2'd0,
        IN_PAYLOAD   = 2'd1,
        AWAIT_CRC    = 2'd2
    } t_frame_phase;

    // Indexes outside the register map, which the block ignores; the stimulus writes to both
    localparam logic [lcfr_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 8'd2;
    localparam logic [lcfr_pkg::CFG_INDEX_W-1:0] REG_LAST_UNUSED  = 8'hFF;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                             cfg_valid = 1'b0;
    logic [lcfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                       cfg_data  = '0;
    logic                             o_cfg_ready;

    logic       in_valid = 1'b0;
    logic [7:0] rx_byte  = '0;
    logic       o_in_stall;

    logic                         out_stall = 1'b0;
    logic                         o_out_valid;
    logic [1:0]                   o_kind;
    logic [7:0]                   o_payload_byte;
    logic [7:0]                   o_byte_index;
    logic [7:0]                   o_frame_length;
    logic [7:0]                   o_computed_crc;
    logic [lcfr_pkg::TOTAL_W-1:0] o_bad_length_total;
    logic [lcfr_pkg::TOTAL_W-1:0] o_crc_fail_total;

    length_crc8_frame_receiver DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_kind             (o_kind),
        .o_payload_byte     (o_payload_byte),
        .o_byte_index       (o_byte_index),
        .o_frame_length     (o_frame_length),
        .o_computed_crc     (o_computed_crc),
        .o_bad_length_total (o_bad_length_total),
        .o_crc_fail_total   (o_crc_fail_total)
    );

    // Bytes waiting to be sent, and reports the tracker expects back
    logic [7:0]        rx_pending [$];
    lcfr_pkg::t_result predicted_reports [$];

    // Tracker copy of the registers
    logic [7:0] cfg_poly = lcfr_pkg::CRC_POLY_RESET;
    logic [7:0] cfg_max  = lcfr_pkg::MAX_PAYLOAD_RESET;

    // Tracker copy of the parser state
    t_frame_phase                 frame_phase  = AWAIT_LENGTH;
    logic [7:0]                   frame_len    = '0;
    logic [7:0]                   got_count    = '0;
    logic [7:0]                   frame_crc    = '0;
    logic [lcfr_pkg::TOTAL_W-1:0] bad_len_seen = '0;
    logic [lcfr_pkg::TOTAL_W-1:0] crc_bad_seen = '0;

    int idle_pct      = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int mismatch_count = 0;
    int unsigned bytes_loaded = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bit-serial CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? poly : 8'h00);
        end
        return c;
    endfunction

    // Advance the frame tracker by one accepted byte
    task automatic track_frame_byte(input logic [7:0] b);
        lcfr_pkg::t_result r;
        r = '0;
        r.payload_byte = b;
        case (frame_phase)
            IN_PAYLOAD: begin
                r.kind         = lcfr_pkg::KIND_PAYLOAD;
                r.byte_index   = got_count;
                r.frame_length = frame_len;
                frame_crc      = crc8_next(frame_crc, b, cfg_poly);
                got_count      = got_count + 8'd1;
                if (got_count == frame_len) begin
                    frame_phase = AWAIT_CRC;
                end
            end
            AWAIT_CRC: begin
                r.frame_length = frame_len;
                r.computed_crc = frame_crc;
                if (frame_crc == b) begin
                    r.kind = lcfr_pkg::KIND_FRAME_GOOD;
                end else begin
                    r.kind       = lcfr_pkg::KIND_CRC_FAIL;
                    crc_bad_seen = crc_bad_seen + 1;
                end
                frame_phase = AWAIT_LENGTH;
                got_count   = '0;
                frame_crc   = '0;
            end
            default: begin
                if (b == 8'd0 || b > cfg_max) begin
                    r.kind         = lcfr_pkg::KIND_BAD_LENGTH;
                    r.frame_length = b;
                    bad_len_seen   = bad_len_seen + 1;
                    frame_phase    = AWAIT_LENGTH;
                end else begin
                    // accepted length: no report
                    frame_len   = b;
                    got_count   = '0;
                    frame_crc   = crc8_next(8'h00, b, cfg_poly);
                    frame_phase = IN_PAYLOAD;
                    return;
                end
            end
        endcase
        r.bad_length_total = bad_len_seen;
        r.crc_fail_total   = crc_bad_seen;
        predicted_reports.push_back(r);
    endtask

    // Byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                track_frame_byte(rx_byte);
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_pending.pop_front();
                    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                        gap_left = $urandom_range(1, 5);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor and receiver stall
    always @(posedge i_clk) begin
        lcfr_pkg::t_result got;
        lcfr_pkg::t_result want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got = '{o_kind, o_payload_byte, o_byte_index, o_frame_length, o_computed_crc,
                        o_bad_length_total, o_crc_fail_total};
                if (predicted_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected report: kind=%0d byte=%h idx=%0d len=%0d crc=%h",
                                 got.kind, got.payload_byte, got.byte_index,
                                 got.frame_length, got.computed_crc);
                    end
                end else begin
                    want = predicted_reports.pop_front();
                    if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                        got.byte_index !== want.byte_index ||
                        got.frame_length !== want.frame_length ||
                        got.computed_crc !== want.computed_crc ||
                        got.bad_length_total !== want.bad_length_total ||
                        got.crc_fail_total !== want.crc_fail_total) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("mismatch at %0t", $realtime);
                            $write("  expected kind=%0d byte=%h idx=%0d len=%0d",
                                   want.kind, want.payload_byte, want.byte_index,
                                   want.frame_length);
                            $display(" crc=%h bad=%0d crcfail=%0d", want.computed_crc,
                                     want.bad_length_total, want.crc_fail_total);
                            $write("  actual   kind=%0d byte=%h idx=%0d len=%0d",
                                   got.kind, got.payload_byte, got.byte_index,
                                   got.frame_length);
                            $display(" crc=%h bad=%0d crcfail=%0d", got.computed_crc,
                                     got.bad_length_total, got.crc_fail_total);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    stall_left = $urandom_range(1, 5);
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any transaction
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAIL length_crc8_frame_receiver");
        $finish;
    end

    task automatic load_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_loaded++;
    endtask

    // Queue a full frame; the CRC byte is built with the current polynomial
    task automatic push_frame(input t_byte_list body, input bit bad_crc);
        logic [7:0] c;
        c = crc8_next(8'h00, 8'(body.size()), cfg_poly);
        load_byte(8'(body.size()));
        foreach (body[k]) begin
            c = crc8_next(c, body[k], cfg_poly);
            load_byte(body[k]);
        end
        if (bad_crc) begin
            c = c ^ 8'($urandom_range(1, 255));
        end
        load_byte(c);
    endtask

    // Wait until every byte is in and every report is out, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (rx_pending.size() != 0 || in_valid || predicted_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [lcfr_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [7:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == lcfr_pkg::REG_CRC_POLY) begin
            cfg_poly = val;
        end else if (idx == lcfr_pkg::REG_MAX_PAYLOAD) begin
            cfg_max = val;
        end
        @(negedge i_clk);
    endtask

    // Mostly well-formed frames with random content, plus bad lengths,
    // cut-off frames and loose bytes
    task automatic load_random_traffic(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        int unsigned top;
        int unsigned cut;
        t_byte_list  body;
        start = bytes_loaded;
        top   = (cfg_max < 8) ? cfg_max : 8;
        while (bytes_loaded - start < count) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 29) == 0) ? cfg_max : $urandom_range(1, top);
            if (pick < 75) begin
                body = {};
                repeat (len) body.push_back(8'($urandom_range(0, 255)));
                push_frame(body, $urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                if (cfg_max == 8'd255 || $urandom_range(0, 2) == 0) begin
                    load_byte(8'h00);
                end else begin
                    load_byte(8'($urandom_range(cfg_max + 1, 255)));
                end
            end else if (pick < 93) begin
                // frame cut short: what follows is taken as its payload
                load_byte(8'(len));
                cut = $urandom_range(0, len - 1);
                repeat (cut) load_byte(8'($urandom_range(0, 255)));
            end else begin
                load_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stimulus sequence
    initial begin : stimulus
        t_byte_list  body;
        logic [7:0]  poly;
        logic [7:0]  maxp;
        logic [7:0]  c;
        int          pct;
        int unsigned count;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset register values: bad lengths at both ends, short frames
        idle_pct = 20;
        load_byte(8'h00);
        load_byte(8'd65);
        load_byte(8'hFF);
        body = '{8'h00};
        push_frame(body, 1'b0);
        body = '{8'hFF, 8'h80};
        push_frame(body, 1'b1);
        body = '{8'hFF};
        push_frame(body, 1'b0);
        drain();

        // Writes to unused indexes leave the registers alone
        write_register(REG_FIRST_UNUSED, 8'h00);
        write_register(REG_LAST_UNUSED, 8'hAA);

        // Zero maximum payload rejects every length
        write_register(lcfr_pkg::REG_MAX_PAYLOAD, 8'd0);
        load_byte(8'h01);
        load_byte(8'hFF);
        drain();

        // Smallest maximum with an all-zero polynomial
        write_register(lcfr_pkg::REG_MAX_PAYLOAD, 8'd1);
        write_register(lcfr_pkg::REG_CRC_POLY, 8'h00);
        body = '{8'hA5};
        push_frame(body, 1'b0);
        load_byte(8'h02);
        drain();

        // Maximum lowered while a frame is open: the frame keeps its length
        write_register(lcfr_pkg::REG_CRC_POLY, 8'hFF);
        write_register(lcfr_pkg::REG_MAX_PAYLOAD, 8'd4);
        load_byte(8'h03);
        load_byte(8'h11);
        drain();
        write_register(lcfr_pkg::REG_MAX_PAYLOAD, 8'd1);
        c = crc8_next(8'h00, 8'h03, cfg_poly);
        c = crc8_next(c, 8'h11, cfg_poly);
        c = crc8_next(c, 8'h22, cfg_poly);
        c = crc8_next(c, 8'h33, cfg_poly);
        load_byte(8'h22);
        load_byte(8'h33);
        load_byte(c);
        drain();

        // Random traffic under a series of register settings
        for (int p = 0; p < 8; p++) begin
            count = 170;
            case (p)
                0: begin poly = 8'h07; maxp = 8'd64;  pct = 20; end
                1: begin poly = 8'hFF; maxp = 8'd255; pct = 15; count = 200; end
                2: begin poly = 8'h00; maxp = 8'd1;   pct = 25; count = 150; end
                3: begin poly = 8'h31; maxp = 8'd16;  pct = 0;  count = 150; end
                4: begin
                    poly = 8'($urandom_range(0, 255));
                    maxp = 8'($urandom_range(2, 32));
                    pct  = 20;
                end
                5: begin poly = 8'h1D; maxp = 8'd255; pct = 10; end
                6: begin poly = 8'($urandom_range(0, 255)); maxp = 8'd8; pct = 20; end
                default: begin poly = 8'h9B; maxp = 8'd12; pct = 0; end
            endcase
            idle_pct = pct;
            write_register(lcfr_pkg::REG_CRC_POLY, poly);
            write_register(lcfr_pkg::REG_MAX_PAYLOAD, maxp);
            load_random_traffic(count);
            drain();
        end

        if (mismatch_count == 0 && predicted_reports.size() == 0) begin
            $display("PASS length_crc8_frame_receiver");
        end else begin
            $display("FAIL length_crc8_frame_receiver");
        end
        $finish;
    end

endmodule

>>> files.f
design/lcfr_pkg.sv
design/lcfr_front.sv
design/lcfr_queue.sv
design/lcfr_back.sv
design/length_crc8_frame_receiver.sv
design/lcfr_checker.sv
tb/length_crc8_frame_receiver_test.sv
